@@ rtl/pbu_pkg.sv @@
// Package for the particle boundary unit: item and configuration types,
// register indexes, mode and kind codes, and the saturation helper.
// Has no dependencies; every other file in rtl uses it.
`default_nettype none

package pbu_pkg;

  localparam int unsigned MAX_PARTICLES = 65536;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned SLOT_W = 16;
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_PARTICLES < 65536) ? MAX_PARTICLES : 65536);
  localparam logic [SLOT_W-1:0] SLOT_MAX = '1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOWER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_UPPER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOWER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_UPPER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH = 3'd6;

  localparam logic [2:0] XM_NONE          = 3'd0;
  localparam logic [2:0] XM_PERIODIC      = 3'd1;
  localparam logic [2:0] XM_REFLECT_BOTH  = 3'd2;
  localparam logic [2:0] XM_REFLECT_LEFT  = 3'd3;
  localparam logic [2:0] XM_REFLECT_RIGHT = 3'd4;
  localparam logic [2:0] XM_OPEN_RIGHT    = 3'd5;

  localparam logic [1:0] YM_NONE     = 2'd0;
  localparam logic [1:0] YM_PERIODIC = 2'd1;
  localparam logic [1:0] YM_REFLECT  = 2'd2;

  localparam logic [1:0] KIND_KEEP   = 2'd0;
  localparam logic [1:0] KIND_LEAVE  = 2'd1;
  localparam logic [1:0] KIND_INJECT = 2'd2;

  localparam logic signed [33:0] S34_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S34_MIN = -34'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] prev_x;
    logic               batch_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        slot;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
    logic signed [31:0] new_vz;
    logic               run_last;
    logic               batch_done;
    logic [16:0]        injected_total;
    logic [16:0]        leaving_total;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         x_mode;
    logic [1:0]         y_mode;
    logic signed [31:0] x_lower;
    logic signed [31:0] x_upper;
    logic signed [31:0] y_lower;
    logic signed [31:0] y_upper;
    logic [30:0]        cell_width;
  } cfg_t;

  // Outcome of the boundary rules for one particle.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] x_inj;
    logic               leaving;
    logic               inject;
  } rule_res_t;

  // Counter events, applied when a result enters the output register.
  typedef struct packed {
    logic leave;
    logic inject;
    logic clear;
  } cnt_ev_t;

  typedef struct packed {
    logic [CNT_W-1:0]  inj_cnt;
    logic [CNT_W-1:0]  lv_cnt;
    logic [CNT_W-1:0]  inj_inc;
    logic [CNT_W-1:0]  lv_inc;
    logic [SLOT_W-1:0] inj_slot;
    logic [SLOT_W-1:0] lv_slot;
  } cnt_view_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S34_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S34_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pbu_rule.sv @@
// Boundary rule logic: applies the y rule and the x rule to one particle.
// Purely combinational; uses pbu_pkg for types, codes and saturation.
`default_nettype none

module pbu_rule (
  input  wire pbu_pkg::cfg_t     cfg,
  input  wire pbu_pkg::in_item_t item,
  output pbu_pkg::rule_res_t     res
);

  logic signed [33:0] px, py, vx, vy, prv;
  logic signed [33:0] xu, xl, yu, yl, dx, band;
  logic signed [31:0] vx_neg, vy_neg;
  logic signed [31:0] mir_xu, mir_xl, mir_yu, mir_yl;
  logic               x_ge_up;

  always_comb begin
    px   = {{2{item.pos_x[31]}}, item.pos_x};
    py   = {{2{item.pos_y[31]}}, item.pos_y};
    vx   = {{2{item.vel_x[31]}}, item.vel_x};
    vy   = {{2{item.vel_y[31]}}, item.vel_y};
    prv  = {{2{item.prev_x[31]}}, item.prev_x};
    xu   = {{2{cfg.x_upper[31]}}, cfg.x_upper};
    xl   = {{2{cfg.x_lower[31]}}, cfg.x_lower};
    yu   = {{2{cfg.y_upper[31]}}, cfg.y_upper};
    yl   = {{2{cfg.y_lower[31]}}, cfg.y_lower};
    dx   = {3'b000, cfg.cell_width};
    band = xu - dx;

    vx_neg = pbu_pkg::sat34(-vx);
    vy_neg = pbu_pkg::sat34(-vy);
    mir_xu = pbu_pkg::sat34((xu <<< 1) - px);
    mir_xl = pbu_pkg::sat34((xl <<< 1) - px);
    mir_yu = pbu_pkg::sat34((yu <<< 1) - py);
    mir_yl = pbu_pkg::sat34((yl <<< 1) - py);
    x_ge_up = (px >= xu);

    res.y  = item.pos_y;
    res.vy = item.vel_y;
    unique case (cfg.y_mode)
      pbu_pkg::YM_PERIODIC: begin
        if (py > yu) begin
          res.y = '0;
        end else if (py < 34'sd0) begin
          res.y = pbu_pkg::sat34(yu - 34'sd1);
        end
      end
      pbu_pkg::YM_REFLECT: begin
        if (py >= yu) begin
          res.y  = mir_yu;
          res.vy = vy_neg;
        end else if (py <= yl) begin
          res.y  = mir_yl;
          res.vy = vy_neg;
        end
      end
      default: begin
      end
    endcase

    res.x  = item.pos_x;
    res.vx = item.vel_x;
    unique case (cfg.x_mode)
      pbu_pkg::XM_PERIODIC: begin
        if (px > xu) begin
          res.x = '0;
        end else if (px < 34'sd0) begin
          res.x = pbu_pkg::sat34(xu - 34'sd1);
        end
      end
      pbu_pkg::XM_REFLECT_BOTH: begin
        if (x_ge_up) begin
          res.x  = mir_xu;
          res.vx = vx_neg;
        end else if (px <= xl) begin
          res.x  = mir_xl;
          res.vx = vx_neg;
        end
      end
      pbu_pkg::XM_REFLECT_LEFT: begin
        if (px <= xl) begin
          res.x  = mir_xl;
          res.vx = vx_neg;
        end
      end
      pbu_pkg::XM_REFLECT_RIGHT: begin
        if (x_ge_up) begin
          res.x  = mir_xu;
          res.vx = vx_neg;
        end
      end
      default: begin
      end
    endcase

    res.leaving = (cfg.x_mode == pbu_pkg::XM_OPEN_RIGHT) && x_ge_up;
    res.inject  = (cfg.x_mode == pbu_pkg::XM_OPEN_RIGHT) && !x_ge_up &&
                  (prv > band) && (px < band);
    res.x_inj   = pbu_pkg::sat34(px + dx);
  end

endmodule

`default_nettype wire

@@ rtl/pbu_counter.sv @@
// Batch counters for leaving particles and injected copies, with slot values.
// Uses pbu_pkg for the count cap, widths and the event and view structs.
`default_nettype none

module pbu_counter (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire pbu_pkg::cnt_ev_t   ev,
  output pbu_pkg::cnt_view_t      view
);

  logic [pbu_pkg::CNT_W-1:0] inj_cnt_r, inj_cnt_nxt;
  logic [pbu_pkg::CNT_W-1:0] lv_cnt_r, lv_cnt_nxt;
  logic [pbu_pkg::CNT_W-1:0] inj_inc, lv_inc;

  always_comb begin
    inj_inc = (inj_cnt_r < pbu_pkg::COUNT_CAP) ? inj_cnt_r + 1'b1 : inj_cnt_r;
    lv_inc  = (lv_cnt_r < pbu_pkg::COUNT_CAP) ? lv_cnt_r + 1'b1 : lv_cnt_r;

    inj_cnt_nxt = ev.inject ? inj_inc : inj_cnt_r;
    lv_cnt_nxt  = ev.leave ? lv_inc : lv_cnt_r;
    if (ev.clear) begin
      inj_cnt_nxt = '0;
      lv_cnt_nxt  = '0;
    end

    view.inj_cnt  = inj_cnt_r;
    view.lv_cnt   = lv_cnt_r;
    view.inj_inc  = inj_inc;
    view.lv_inc   = lv_inc;
    view.inj_slot = inj_cnt_r[pbu_pkg::CNT_W-1] ? pbu_pkg::SLOT_MAX
                                                : inj_cnt_r[pbu_pkg::SLOT_W-1:0];
    view.lv_slot  = lv_cnt_r[pbu_pkg::CNT_W-1] ? pbu_pkg::SLOT_MAX
                                               : lv_cnt_r[pbu_pkg::SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_cnt_r <= '0;
      lv_cnt_r  <= '0;
    end else begin
      inj_cnt_r <= inj_cnt_nxt;
      lv_cnt_r  <= lv_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/particle_boundary_unit_top.sv @@
// Top level of the particle boundary unit: input register, configuration
// registers, output register. Uses pbu_pkg, pbu_rule and pbu_counter.
`default_nettype none

// The unit accepts one particle item per clock when in_stall is low; each item
// passes the input register and then the output register. Most particles give
// one result, so items can stream at one per cycle while out_stall is low. A
// particle that makes an injected copy in the open-right mode gives two results
// and holds the input register until both are loaded, since the output register
// takes one result per cycle. Configuration writes take effect at the next edge
// and should be made only while the unit is empty.
module particle_boundary_unit_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire pbu_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output pbu_pkg::out_item_t                  out_data,
  input  wire                                 cfg_we,
  input  wire [pbu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [pbu_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  pbu_pkg::cfg_t      cfg_r, cfg_nxt;
  pbu_pkg::in_item_t  item_r;
  logic               item_vld_r, item_vld_nxt;
  logic               phase_r, phase_nxt;
  pbu_pkg::out_item_t out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;

  pbu_pkg::rule_res_t rule;
  pbu_pkg::cnt_ev_t   cnt_ev;
  pbu_pkg::cnt_view_t cnt;

  logic       out_free, is_last, load, item_done, accept;
  logic [1:0] kind;

  pbu_rule u_rule (
    .cfg  (cfg_r),
    .item (item_r),
    .res  (rule)
  );

  pbu_counter u_counter (
    .clk   (clk),
    .rst_n (rst_n),
    .ev    (cnt_ev),
    .view  (cnt)
  );

  always_comb begin
    out_free  = !out_vld_r || !out_stall;
    is_last   = !rule.inject || phase_r;
    load      = item_vld_r && out_free;
    item_done = load && is_last;
    in_stall  = item_vld_r && !item_done;
    accept    = in_valid && !in_stall;

    item_vld_nxt = accept ? 1'b1 : (item_done ? 1'b0 : item_vld_r);
    phase_nxt    = item_done ? 1'b0 : (load ? 1'b1 : phase_r);
    out_vld_nxt  = load ? 1'b1 : (out_vld_r && out_stall);

    if (rule.leaving) begin
      kind = pbu_pkg::KIND_LEAVE;
    end else if (rule.inject && phase_r) begin
      kind = pbu_pkg::KIND_INJECT;
    end else begin
      kind = pbu_pkg::KIND_KEEP;
    end

    cnt_ev.leave  = load && (kind == pbu_pkg::KIND_LEAVE);
    cnt_ev.inject = load && (kind == pbu_pkg::KIND_INJECT);
    cnt_ev.clear  = item_done && item_r.batch_last;

    out_nxt.kind   = kind;
    out_nxt.slot   = '0;
    if (kind == pbu_pkg::KIND_LEAVE) begin
      out_nxt.slot = cnt.lv_slot;
    end else if (kind == pbu_pkg::KIND_INJECT) begin
      out_nxt.slot = cnt.inj_slot;
    end
    out_nxt.new_x  = (kind == pbu_pkg::KIND_INJECT) ? rule.x_inj : rule.x;
    out_nxt.new_y  = rule.y;
    out_nxt.new_z  = item_r.pos_z;
    out_nxt.new_vx = rule.vx;
    out_nxt.new_vy = rule.vy;
    out_nxt.new_vz = item_r.vel_z;
    out_nxt.run_last   = is_last;
    out_nxt.batch_done = is_last && item_r.batch_last;
    out_nxt.injected_total = (kind == pbu_pkg::KIND_INJECT) ? cnt.inj_inc : cnt.inj_cnt;
    out_nxt.leaving_total  = (kind == pbu_pkg::KIND_LEAVE) ? cnt.lv_inc : cnt.lv_cnt;

    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pbu_pkg::REG_X_MODE:     cfg_nxt.x_mode     = cfg_wdata[2:0];
        pbu_pkg::REG_Y_MODE:     cfg_nxt.y_mode     = cfg_wdata[1:0];
        pbu_pkg::REG_X_LOWER:    cfg_nxt.x_lower    = cfg_wdata;
        pbu_pkg::REG_X_UPPER:    cfg_nxt.x_upper    = cfg_wdata;
        pbu_pkg::REG_Y_LOWER:    cfg_nxt.y_lower    = cfg_wdata;
        pbu_pkg::REG_Y_UPPER:    cfg_nxt.y_upper    = cfg_wdata;
        pbu_pkg::REG_CELL_WIDTH: cfg_nxt.cell_width = cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_mode     <= pbu_pkg::XM_NONE;
      cfg_r.y_mode     <= pbu_pkg::YM_NONE;
      cfg_r.x_lower    <= 32'sd0;
      cfg_r.x_upper    <= 32'sd4194304;
      cfg_r.y_lower    <= 32'sd0;
      cfg_r.y_upper    <= 32'sd4194304;
      cfg_r.cell_width <= 31'd65536;
      item_vld_r       <= 1'b0;
      phase_r          <= 1'b0;
      out_vld_r        <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      item_vld_r <= item_vld_nxt;
      phase_r    <= phase_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for particle_boundary_unit_top: streams particles with random
// gaps and output stalls, and checks every result against a boundary-rule predictor.
// Depends on pbu_pkg and the RTL top level; needs no files or arguments.
module tb;
  import pbu_pkg::*;

  localparam logic [2:0] XM_UNDEF_A = 3'd6;
  localparam logic [2:0] XM_UNDEF_B = 3'd7;
  localparam logic [1:0] YM_UNDEF = 2'd3;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 140;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [2:0] m_xmode = XM_NONE;
  logic [1:0] m_ymode = YM_NONE;
  longint wall_xl = 0;
  longint wall_xu = 4194304;
  longint wall_yl = 0;
  longint wall_yu = 4194304;
  longint cell_w = 65536;
  int unsigned inj_total = 0;
  int unsigned leave_total = 0;

  in_item_t pending_particles[$];
  out_item_t expected_results[$];
  int offered_count = 0;
  int taken_count = 0;
  int error_count = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  particle_boundary_unit_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint wrap_periodic(longint p, longint upper);
    if (p > upper) return 0;
    if (p < 0) return clamp32(upper - 1);
    return p;
  endfunction

  function automatic void mirror(inout longint p, inout longint v, input longint wall);
    p = clamp32(2 * wall - p);
    v = clamp32(-v);
  endfunction

  function automatic logic [15:0] slot_for(int unsigned cnt);
    return (cnt > 65535) ? SLOT_MAX : cnt[15:0];
  endfunction

  function automatic out_item_t result_of(logic [1:0] kind, logic [15:0] slot, longint x,
                                          longint y, longint vx, longint vy, in_item_t it,
                                          bit last, bit done);
    out_item_t r;
    r.kind = kind;
    r.slot = slot;
    r.new_x = x[31:0];
    r.new_y = y[31:0];
    r.new_z = it.pos_z;
    r.new_vx = vx[31:0];
    r.new_vy = vy[31:0];
    r.new_vz = it.vel_z;
    r.run_last = last;
    r.batch_done = done;
    r.injected_total = inj_total[16:0];
    r.leaving_total = leave_total[16:0];
    return r;
  endfunction

  function automatic void predict_boundary(in_item_t it);
    longint x, y, vx, vy, px, band;
    logic [15:0] s;
    bit done;
    bit emitted;
    x = $signed(it.pos_x);
    y = $signed(it.pos_y);
    vx = $signed(it.vel_x);
    vy = $signed(it.vel_y);
    px = $signed(it.prev_x);
    band = wall_xu - cell_w;
    done = it.batch_last;
    emitted = 1'b0;
    case (m_ymode)
      YM_PERIODIC: y = wrap_periodic(y, wall_yu);
      YM_REFLECT: begin
        if (y >= wall_yu) mirror(y, vy, wall_yu);
        else if (y <= wall_yl) mirror(y, vy, wall_yl);
      end
      default: ;
    endcase
    case (m_xmode)
      XM_PERIODIC: x = wrap_periodic(x, wall_xu);
      XM_REFLECT_BOTH: begin
        if (x >= wall_xu) mirror(x, vx, wall_xu);
        else if (x <= wall_xl) mirror(x, vx, wall_xl);
      end
      XM_REFLECT_LEFT: begin
        if (x <= wall_xl) mirror(x, vx, wall_xl);
      end
      XM_REFLECT_RIGHT: begin
        if (x >= wall_xu) mirror(x, vx, wall_xu);
      end
      XM_OPEN_RIGHT: begin
        if (x >= wall_xu) begin
          s = slot_for(leave_total);
          if (leave_total < COUNT_CAP) leave_total++;
          expected_results.push_back(result_of(KIND_LEAVE, s, x, y, vx, vy, it, 1'b1, done));
          emitted = 1'b1;
        end else if (px > band && x < band) begin
          expected_results.push_back(result_of(KIND_KEEP, '0, x, y, vx, vy, it, 1'b0, 1'b0));
          s = slot_for(inj_total);
          if (inj_total < COUNT_CAP) inj_total++;
          expected_results.push_back(result_of(KIND_INJECT, s, clamp32(x + cell_w), y, vx, vy,
                                               it, 1'b1, done));
          emitted = 1'b1;
        end
      end
      default: ;
    endcase
    if (!emitted) begin
      expected_results.push_back(result_of(KIND_KEEP, '0, x, y, vx, vy, it, 1'b1, done));
    end
    if (done) begin
      inj_total = 0;
      leave_total = 0;
    end
  endfunction

  function automatic logic [31:0] q(int n);
    return 32'(n) << 16;
  endfunction

  function automatic logic [31:0] around(longint w, int unsigned spread);
    return w[31:0] + $urandom_range(0, 2 * spread) - spread;
  endfunction

  function automatic logic [31:0] pick_coord(longint lo, longint hi);
    longint span;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return around(lo, 4);
      3: return around(hi, 4);
      4: return around(0, 4);
      5: return around(lo, 1 << 18);
      6: return around(hi, 1 << 18);
      default: begin
        span = hi - lo;
        if (span <= 0) return around(hi, 1 << 20);
        return around(lo + longint'($urandom) % (span + 1), 0);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 7))
      0: return MINV;
      1: return MAXV;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_particle();
    in_item_t it;
    longint band;
    band = wall_xu - cell_w;
    it.pos_x = pick_coord(wall_xl, wall_xu);
    it.pos_y = pick_coord(wall_yl, wall_yu);
    it.pos_z = $urandom;
    it.vel_x = pick_vel();
    it.vel_y = pick_vel();
    it.vel_z = $urandom;
    it.prev_x = pick_coord(wall_xl, wall_xu);
    if (m_xmode == XM_OPEN_RIGHT && $urandom_range(0, 2) == 0) begin
      it.prev_x = around(band, 0) + $urandom_range(1, 1 << 17);
      it.pos_x = around(band, 0) - $urandom_range(1, 1 << 17);
    end
    it.batch_last = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  function automatic in_item_t particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                       logic [31:0] px, logic last);
    in_item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.vel_x = vx;
    it.vel_y = vy;
    it.vel_z = vz;
    it.prev_x = px;
    it.batch_last = last;
    return it;
  endfunction

  task automatic wait_idle();
    int n;
    n = 0;
    while ((pending_particles.size() > 0 || offered_count != taken_count ||
            expected_results.size() > 0) && n < 50000) begin
      @(posedge clk);
      n++;
    end
    if (expected_results.size() > 0) begin
      error_count++;
      $error("%0d expected results never arrived", expected_results.size());
      expected_results.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_X_MODE: m_xmode = v[2:0];
      REG_Y_MODE: m_ymode = v[1:0];
      REG_X_LOWER: wall_xl = $signed(v);
      REG_X_UPPER: wall_xu = $signed(v);
      REG_Y_LOWER: wall_yl = $signed(v);
      REG_Y_UPPER: wall_yu = $signed(v);
      REG_CELL_WIDTH: cell_w = v[30:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [2:0] xm, logic [1:0] ym, logic [31:0] xl, logic [31:0] xu,
                           logic [31:0] yl, logic [31:0] yu, logic [31:0] cw);
    wait_idle();
    write_reg(REG_X_MODE, 32'(xm));
    write_reg(REG_Y_MODE, 32'(ym));
    write_reg(REG_X_LOWER, xl);
    write_reg(REG_X_UPPER, xu);
    write_reg(REG_Y_LOWER, yl);
    write_reg(REG_Y_UPPER, yu);
    write_reg(REG_CELL_WIDTH, cw);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int ph);
    logic [2:0] xm;
    logic [1:0] ym;
    logic [31:0] xl, xu, yl, yu, cw;
    case (ph)
      1: xm = XM_PERIODIC;
      2, 9: xm = XM_REFLECT_BOTH;
      3: xm = XM_REFLECT_LEFT;
      4: xm = XM_REFLECT_RIGHT;
      6: xm = XM_NONE;
      7: xm = XM_UNDEF_A;
      10: xm = XM_UNDEF_B;
      default: xm = XM_OPEN_RIGHT;
    endcase
    case (ph % 4)
      0: ym = YM_REFLECT;
      1: ym = YM_PERIODIC;
      2: ym = YM_NONE;
      default: ym = YM_UNDEF;
    endcase
    if (ph == 3 || ph == 5 || ph == 9) begin
      xl = MINV;
      xu = MAXV;
      yl = MINV;
      yu = MAXV;
      cw = 32'hffff_ffff;
    end else if (ph == 6 || ph == 8 || ph == 10) begin
      xl = $urandom;
      xu = $urandom;
      yl = $urandom;
      yu = $urandom;
      cw = $urandom;
    end else begin
      xl = q($urandom_range(0, 16)) - q(8);
      xu = xl + q($urandom_range(1, 64));
      yl = q($urandom_range(0, 16)) - q(8);
      yu = yl + q($urandom_range(1, 64));
      cw = $urandom_range(32'h4000, 32'h4_0000) | ($urandom_range(0, 1) << 31);
    end
    if (ph == 11) cw = '0;
    configure(xm, ym, xl, xu, yl, yu, cw);
    quiet = (ph == 4 || ph == 10);
    repeat (PHASE_ITEMS) pending_particles.push_back(random_particle());
    if (ph == 2 || ph == 7 || ph == 11) hold_req = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_particles.size() > 0) begin
        in_data <= pending_particles.pop_front();
        offered_count++;
        in_valid <= 1'b1;
        tx_gap = quiet ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall && !quiet) begin
      rx_wait = $urandom_range(0, 7);
      out_stall <= (rx_wait > 0);
      if (rx_wait > 0) rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_boundary(in_data);
        taken_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $error("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("slot", want.slot, out_data.slot);
          check_field("new_x", want.new_x, out_data.new_x);
          check_field("new_y", want.new_y, out_data.new_y);
          check_field("new_z", want.new_z, out_data.new_z);
          check_field("new_vx", want.new_vx, out_data.new_vx);
          check_field("new_vy", want.new_vy, out_data.new_vy);
          check_field("new_vz", want.new_vz, out_data.new_vz);
          check_field("run_last", want.run_last, out_data.run_last);
          check_field("batch_done", want.batch_done, out_data.batch_done);
          check_field("injected_total", want.injected_total, out_data.injected_total);
          check_field("leaving_total", want.leaving_total, out_data.leaving_total);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes with the reset settings.
    pending_particles.push_back(particle(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b0));
    pending_particles.push_back(particle(MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1));
    pending_particles.push_back(particle('0, '0, '0, '0, '0, '0, '0, 1'b0));

    // Periodic wrap on both axes; the y wall at the minimum makes upper minus one saturate.
    configure(XM_PERIODIC, YM_PERIODIC, '0, q(64), '0, MINV, Q_ONE);
    pending_particles.push_back(particle(q(70), MINV, q(1), q(2), q(3), q(4), q(60), 1'b0));
    pending_particles.push_back(particle(32'hffff_ffff, q(5), q(1), q(2), q(3), q(4), '0, 1'b0));
    pending_particles.push_back(particle(q(64), '0, q(1), q(2), q(3), q(4), '0, 1'b0));

    // Crossed x walls so the upper test must win; y mirrors saturate both ways.
    configure(XM_REFLECT_BOTH, YM_REFLECT, q(10), q(5), 32'h4000_0000, 32'hc000_0000, Q_ONE);
    pending_particles.push_back(particle(q(7), MAXV, '0, MINV, q(5), q(1), q(6), 1'b0));
    pending_particles.push_back(particle(q(2), MINV, '0, q(3), MINV, '0, q(1), 1'b0));

    configure(XM_REFLECT_LEFT, YM_UNDEF, '0, q(64), '0, q(64), Q_ONE);
    pending_particles.push_back(particle(q(-1), q(100), '0, q(2), q(2), '0, '0, 1'b0));
    pending_particles.push_back(particle(q(70), q(-3), '0, q(2), q(2), '0, '0, 1'b0));

    configure(XM_REFLECT_RIGHT, YM_NONE, '0, q(64), '0, q(64), Q_ONE);
    pending_particles.push_back(particle(q(70), q(1), '0, q(-2), q(2), '0, '0, 1'b0));
    pending_particles.push_back(particle(q(-1), q(1), '0, q(-2), q(2), '0, '0, 1'b0));

    // Open right edge: leaving, injection across the band, its borders, and a batch end.
    configure(XM_OPEN_RIGHT, YM_PERIODIC, '0, q(64), '0, q(64), Q_ONE);
    pending_particles.push_back(particle(q(70), q(65), '0, q(1), q(1), '0, q(69), 1'b0));
    pending_particles.push_back(particle(q(64), q(-1), '0, q(1), q(1), '0, q(63), 1'b0));
    pending_particles.push_back(particle(q(62) + 32'h8000, q(3), q(1), q(1), q(1), q(1),
                                         q(63) + 32'h8000, 1'b0));
    pending_particles.push_back(particle(q(62), q(3), '0, q(1), q(1), '0, q(63), 1'b0));
    pending_particles.push_back(particle(q(63), q(3), '0, q(1), q(1), '0, q(64), 1'b0));
    pending_particles.push_back(particle(q(62), q(3), '0, q(1), q(1), '0, q(64), 1'b1));
    pending_particles.push_back(particle(q(80), q(3), '0, q(1), q(1), '0, q(70), 1'b0));

    configure(XM_UNDEF_A, YM_UNDEF, '0, q(64), '0, q(64), Q_ONE);
    pending_particles.push_back(particle(q(70), q(70), '0, q(1), q(1), '0, '0, 1'b1));

    for (int ph = 0; ph < 12; ph++) random_phase(ph);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
